// ===== rtl/core/spts_pkg.sv =====
// Shared types and constants for the strict priority thread scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package spts_pkg;

    // Default sizing, handed to the top level parameters
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int LEVELS_DEF      = 4;
    localparam int ID_BITS_DEF     = 16;

    // Fixed port widths
    localparam int KIND_W       = 2;
    localparam int PRIO_W       = 3;
    localparam int STATUS_W     = 3;
    localparam int TID_PORT_W   = 16;
    localparam int LEVEL_PORT_W = 2;

    // Level and thread id after reset
    localparam int LEVEL_TOP = 0;
    localparam int BOOT_TID  = 0;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_CREATE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_YIELD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TERMINATE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PRIO    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_STARTED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_IDS      = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic latch;     // capture the input transfer
        logic exec;      // decide, push, update ids
        logic dispatch;  // pick highest priority (lowest numbered) non-empty queue, issue store read
        logic load;      // take read data as running id
        logic result;    // load the output register
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_dispatch;
    } dp_stat_t;

endpackage

// ===== rtl/core/strict_priority_thread_scheduler.sv =====
// Strict priority thread scheduler, LEVELS FIFO ready queues, level 0 first.
// Steps: latch, exec, result; terminate and dispatching yields add a dispatch
// step and a load step (registered read of the queue store) before the result.
// One item at a time: s_ready returns only after the result is registered.
// Reset (aresetn, synchronous): main thread runs, queues empty, next id 1;
// store contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module strict_priority_thread_scheduler import spts_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [KIND_W-1:0]       s_kind,
    input  logic [PRIO_W-1:0]       s_priority_req,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STATUS_W-1:0]     m_status,
    output logic [TID_PORT_W-1:0]   m_new_tid,
    output logic [TID_PORT_W-1:0]   m_running_tid,
    output logic [LEVEL_PORT_W-1:0] m_running_priority,
    output logic                    m_idle
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    // Sequencer
    spts_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Queues and thread state
    spts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LEVELS      (LEVELS),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_kind             (s_kind),
        .s_priority_req     (s_priority_req),
        .cmd                (cmd),
        .stat               (stat),
        .m_status           (m_status),
        .m_new_tid          (m_new_tid),
        .m_running_tid      (m_running_tid),
        .m_running_priority (m_running_priority),
        .m_idle             (m_idle)
    );

`ifndef NO_ASSERTIONS
    // An accepted transfer makes the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while previous item in progress");

    // Idle result reports no running thread
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_idle) |-> (m_running_tid == '0 && m_running_priority == '0))
        else $error("idle result carries a running thread");

    // Only a successful create hands out an id
    a_tid_on_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_new_tid == '0))
        else $error("new id reported on failed request");
`endif

endmodule

// ===== rtl/core/spts_ctrl.sv =====
// Sequencing state machine of the scheduler: input and output handshakes,
// step commands to the datapath. Depends on spts_pkg.
`timescale 1ns / 1ps

module spts_ctrl import spts_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output ctl_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_LOAD = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // Next state and commands
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = stat.need_dispatch ? S_DISP : S_DONE;
            end
            S_DISP: begin
                cmd.dispatch = 1'b1;
                state_next   = S_LOAD;
            end
            S_LOAD: begin
                cmd.load   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                // wait for a free output register
                if (!m_valid_reg || m_ready) begin
                    cmd.result   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/core/spts_datapath.sv =====
// Scheduler datapath: ready queue store, per level pointers and counts,
// running thread state, id counter and output register. Depends on spts_pkg.
`timescale 1ns / 1ps

module spts_datapath import spts_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int LEVELS      = LEVELS_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [KIND_W-1:0]       s_kind,
    input  logic [PRIO_W-1:0]       s_priority_req,
    input  ctl_cmd_t                cmd,
    output dp_stat_t                stat,
    output logic [STATUS_W-1:0]     m_status,
    output logic [TID_PORT_W-1:0]   m_new_tid,
    output logic [TID_PORT_W-1:0]   m_running_tid,
    output logic [LEVEL_PORT_W-1:0] m_running_priority,
    output logic                    m_idle
);

    localparam int LVL_W       = (LEVELS > 2) ? $clog2(LEVELS) : 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_DEPTH = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TID_WIDE    = (ID_BITS > TID_PORT_W) ? ID_BITS : TID_PORT_W;
    localparam int LVL_WIDE    = (LVL_W > LEVEL_PORT_W) ? LVL_W : LEVEL_PORT_W;

    // Ready queue store, one ring of QUEUE_DEPTH entries per level
    logic [ID_BITS-1:0] store_mem [STORE_DEPTH];
    logic [ID_BITS-1:0] rdata_reg;
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ID_BITS-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;

    // Control state
    logic [KIND_W-1:0]   kind_reg,     kind_next;
    logic [PRIO_W-1:0]   prio_reg,     prio_next;
    logic [PTR_W-1:0]    head_reg      [LEVELS];
    logic [PTR_W-1:0]    head_next     [LEVELS];
    logic [PTR_W-1:0]    tail_reg      [LEVELS];
    logic [PTR_W-1:0]    tail_next     [LEVELS];
    logic [CNT_W-1:0]    count_reg     [LEVELS];
    logic [CNT_W-1:0]    count_next    [LEVELS];
    logic [ID_BITS-1:0]  cur_tid_reg,  cur_tid_next;
    logic [LVL_W-1:0]    cur_lvl_reg,  cur_lvl_next;
    logic [ID_BITS:0]    next_id_reg,  next_id_next;
    logic                started_reg,  started_next;
    logic                cpu_idle_reg, cpu_idle_next;
    logic [STATUS_W-1:0] status_reg,   status_next;
    logic [ID_BITS-1:0]  created_reg,  created_next;
    logic                hit_reg,      hit_next;

    // Output register
    logic [STATUS_W-1:0]     out_status_reg;
    logic [TID_PORT_W-1:0]   out_new_tid_reg;
    logic [TID_PORT_W-1:0]   out_run_tid_reg;
    logic [LEVEL_PORT_W-1:0] out_run_lvl_reg;
    logic                    out_idle_reg;

    // Exec helpers
    logic               push_en;
    logic [LVL_W-1:0]   push_lvl;
    logic [LVL_W-1:0]   prio_lvl;
    logic               prio_ok;
    logic               any_ready;
    logic               need_disp;
    logic               sel_found;
    logic [LVL_W-1:0]   sel_lvl;
    logic [TID_WIDE-1:0] created_wide;
    logic [TID_WIDE-1:0] run_tid_wide;
    logic [LVL_WIDE-1:0] run_lvl_wide;

    function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
        return (int'(p) == QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [LVL_W-1:0] lvl,
                                                     input logic [PTR_W-1:0] p);
        return ADDR_W'(int'(lvl) * QUEUE_DEPTH + int'(p));
    endfunction

    assign prio_lvl = prio_reg[LVL_W-1:0];
    assign prio_ok  = (int'(prio_reg) < LEVELS);

    // Any queue non-empty, and highest priority (lowest numbered) non-empty level
    always_comb begin
        any_ready = 1'b0;
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (count_reg[l] != '0) begin
                any_ready = 1'b1;
                sel_found = 1'b1;
                sel_lvl   = LVL_W'(l);
            end
        end
    end

    // Step logic
    always_comb begin
        kind_next     = kind_reg;
        prio_next     = prio_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        cur_tid_next  = cur_tid_reg;
        cur_lvl_next  = cur_lvl_reg;
        next_id_next  = next_id_reg;
        started_next  = started_reg;
        cpu_idle_next = cpu_idle_reg;
        status_next   = status_reg;
        created_next  = created_reg;
        hit_next      = hit_reg;
        push_en       = 1'b0;
        push_lvl      = cur_lvl_reg;
        wdata         = cur_tid_reg;
        need_disp     = 1'b0;
        re            = 1'b0;
        raddr         = store_addr(sel_lvl, head_reg[sel_lvl]);

        if (cmd.latch) begin
            kind_next = s_kind;
            prio_next = s_priority_req;
        end

        if (cmd.exec) begin
            status_next  = ST_OK;
            created_next = '0;
            case (kind_reg)
                KIND_CREATE: begin
                    started_next = 1'b1;
                    if (next_id_reg[ID_BITS]) begin
                        status_next = ST_NO_IDS;
                    end else begin
                        next_id_next = next_id_reg + {{ID_BITS{1'b0}}, 1'b1};
                        if (!prio_ok) begin
                            status_next = ST_BAD_PRIO;
                        end else if (count_reg[prio_lvl] == CNT_W'(QUEUE_DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            push_en      = 1'b1;
                            push_lvl     = prio_lvl;
                            wdata        = next_id_reg[ID_BITS-1:0];
                            created_next = next_id_reg[ID_BITS-1:0];
                        end
                    end
                end
                KIND_YIELD: begin
                    if (!started_reg) begin
                        status_next = ST_NOT_STARTED;
                    end else if (!any_ready) begin
                        status_next = ST_EMPTY;
                    end else if (cpu_idle_reg) begin
                        need_disp = 1'b1;
                    end else if (count_reg[cur_lvl_reg] == CNT_W'(QUEUE_DEPTH)) begin
                        status_next = ST_FULL;
                    end else begin
                        // requeue runner at the tail of its own level
                        push_en   = 1'b1;
                        need_disp = 1'b1;
                    end
                end
                KIND_TERMINATE: begin
                    need_disp = 1'b1;
                end
                default: begin
                end
            endcase
            if (push_en) begin
                tail_next[push_lvl]  = wrap_next(tail_reg[push_lvl]);
                count_next[push_lvl] = count_reg[push_lvl] + 1'b1;
            end
        end

        // Dispatch: pop the head of the highest priority (lowest numbered) non-empty level
        if (cmd.dispatch) begin
            if (sel_found) begin
                re                    = 1'b1;
                head_next[sel_lvl]    = wrap_next(head_reg[sel_lvl]);
                count_next[sel_lvl]   = count_reg[sel_lvl] - 1'b1;
                cur_lvl_next          = sel_lvl;
                cpu_idle_next         = 1'b0;
                hit_next              = 1'b1;
            end else begin
                cpu_idle_next = 1'b1;
                cur_tid_next  = '0;
                cur_lvl_next  = '0;
                hit_next      = 1'b0;
            end
        end

        if (cmd.load && hit_reg) begin
            cur_tid_next = rdata_reg;
        end
    end

    assign we    = cmd.exec && push_en;
    assign waddr = store_addr(push_lvl, tail_reg[push_lvl]);

    assign stat.need_dispatch = need_disp;

    // Store write port
    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
    end

    // Store read port, registered
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    // Control state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            cur_tid_reg  <= ID_BITS'(BOOT_TID);
            cur_lvl_reg  <= LVL_W'(LEVEL_TOP);
            next_id_reg  <= {{ID_BITS{1'b0}}, 1'b1};
            started_reg  <= 1'b0;
            cpu_idle_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            cur_tid_reg  <= cur_tid_next;
            cur_lvl_reg  <= cur_lvl_next;
            next_id_reg  <= next_id_next;
            started_reg  <= started_next;
            cpu_idle_reg <= cpu_idle_next;
            hit_reg      <= hit_next;
        end
    end

    // Per item payload registers
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        prio_reg    <= prio_next;
        status_reg  <= status_next;
        created_reg <= created_next;
    end

    // Output register load
    assign created_wide = TID_WIDE'(created_reg);
    assign run_tid_wide = cpu_idle_reg ? '0 : TID_WIDE'(cur_tid_reg);
    assign run_lvl_wide = cpu_idle_reg ? '0 : LVL_WIDE'(cur_lvl_reg);

    always_ff @(posedge aclk) begin
        if (cmd.result) begin
            out_status_reg  <= status_reg;
            out_new_tid_reg <= created_wide[TID_PORT_W-1:0];
            out_run_tid_reg <= run_tid_wide[TID_PORT_W-1:0];
            out_run_lvl_reg <= run_lvl_wide[LEVEL_PORT_W-1:0];
            out_idle_reg    <= cpu_idle_reg;
        end
    end

    assign m_status           = out_status_reg;
    assign m_new_tid          = out_new_tid_reg;
    assign m_running_tid      = out_run_tid_reg;
    assign m_running_priority = out_run_lvl_reg;
    assign m_idle             = out_idle_reg;

endmodule
